>>> hw/rtl/lzwvu_pkg.sv
`timescale 1ns / 1ps

package lzwvu_pkg;

	localparam int DEF_INIT_WIDTH = 9;
	localparam int DEF_MAX_WIDTH  = 16;

	localparam int BYTE_W     = 8;
	localparam int CODE_W     = 16;
	localparam int LIMIT_W    = 17;
	localparam int ACC_W      = 24;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BITS        = 3'd0,
		REG_MAX_MAX_CODE    = 3'd1,
		REG_CLEAR_CODE      = 3'd2,
		REG_SOH_CODE        = 3'd3,
		REG_STX_CODE        = 3'd4,
		REG_FIRST_FREE_CODE = 3'd5
	} cfg_reg_t;

	localparam logic [COUNT_W-1:0] RST_MAX_BITS        = 5'd16;
	localparam logic [LIMIT_W-1:0] RST_MAX_MAX_CODE    = 17'd65536;
	localparam logic [CODE_W-1:0]  RST_CLEAR_CODE      = 16'd256;
	localparam logic [CODE_W-1:0]  RST_SOH_CODE        = 16'd257;
	localparam logic [CODE_W-1:0]  RST_STX_CODE        = 16'd258;
	localparam logic [CODE_W-1:0]  RST_FIRST_FREE_CODE = 16'd259;

	typedef struct packed {
		logic [COUNT_W-1:0] max_bits;
		logic [LIMIT_W-1:0] max_max_code;
		logic [CODE_W-1:0]  clear_code;
		logic [CODE_W-1:0]  soh_code;
		logic [CODE_W-1:0]  stx_code;
		logic [CODE_W-1:0]  first_free_code;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  data_byte;
		logic               stream_end;
		logic [LIMIT_W-1:0] dict_next;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_value;
		logic              code_valid;
		logic              end_of_stream;
	} result_t;

endpackage

>>> hw/rtl/lzwvu_step.sv
`timescale 1ns / 1ps

module lzwvu_step #(
	parameter int INIT_WIDTH = lzwvu_pkg::DEF_INIT_WIDTH,
	parameter int MAX_WIDTH  = lzwvu_pkg::DEF_MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  lzwvu_pkg::item_t   item,
	input  lzwvu_pkg::cfg_t    cfg,
	output logic               has_result,
	output lzwvu_pkg::result_t res
);
	import lzwvu_pkg::*;

	localparam logic [COUNT_W-1:0] INIT_W    = COUNT_W'(INIT_WIDTH);
	localparam logic [COUNT_W-1:0] MAX_W     = COUNT_W'(MAX_WIDTH);
	localparam logic [LIMIT_W-1:0] INIT_LIM  = LIMIT_W'((1 << INIT_WIDTH) - 1);

	logic [ACC_W-1:0]   acc_q;
	logic [COUNT_W-1:0] bits_held_q;
	logic [COUNT_W-1:0] code_width_q;
	logic [LIMIT_W-1:0] width_limit_q;
	logic [COUNT_W-1:0] group_left_q;
	logic               discarding_q;
	logic               check_pending_q;

	logic [ACC_W-1:0]   acc_d;
	logic [COUNT_W-1:0] bits_d;
	logic [COUNT_W-1:0] cw_d;
	logic [LIMIT_W-1:0] lim_d;
	logic [COUNT_W-1:0] group_d;
	logic               disc_d;
	logic               chk_d;
	logic               have_code;
	logic [CODE_W-1:0]  code;
	logic [COUNT_W-1:0] cap;
	logic [LIMIT_W-1:0] code_mask;

	function automatic logic [LIMIT_W-1:0] ones_below(input logic [COUNT_W-1:0] w);
		return (LIMIT_W'(1) << w) - LIMIT_W'(1);
	endfunction

	// width cap: min(max_bits, MAX_WIDTH), never below the initial width
	always_comb begin
		cap = (cfg.max_bits < MAX_W) ? cfg.max_bits : MAX_W;
		if (cap < INIT_W) begin
			cap = INIT_W;
		end
	end

	always_comb begin
		acc_d     = acc_q;
		bits_d    = bits_held_q;
		cw_d      = code_width_q;
		lim_d     = width_limit_q;
		group_d   = group_left_q;
		disc_d    = discarding_q;
		chk_d     = check_pending_q;
		have_code = 1'b0;
		code      = '0;
		code_mask = '0;

		// width growth check for the code after the one last emitted
		if (check_pending_q) begin
			chk_d = 1'b0;
			if (item.dict_next > width_limit_q && code_width_q < cap) begin
				cw_d   = code_width_q + COUNT_W'(1);
				lim_d  = (cw_d == cfg.max_bits) ? cfg.max_max_code : ones_below(cw_d);
				acc_d  = '0;
				bits_d = '0;
				if (group_left_q != '0) begin
					disc_d = 1'b1;
				end
			end
		end

		if (disc_d) begin
			if (group_d != '0) begin
				group_d = group_d - COUNT_W'(1);
			end
			if (group_d == '0) begin
				disc_d = 1'b0;
			end
		end else begin
			if (group_d == '0) begin
				group_d = cw_d;
			end
			acc_d   = acc_d | (ACC_W'(item.data_byte) << bits_d);
			bits_d  = bits_d + COUNT_W'(BYTE_W);
			group_d = group_d - COUNT_W'(1);
			if (bits_d >= cw_d) begin
				code_mask = ones_below(cw_d);
				code      = acc_d[CODE_W-1:0] & code_mask[CODE_W-1:0];
				acc_d     = acc_d >> cw_d;
				bits_d    = bits_d - cw_d;
				have_code = 1'b1;
				chk_d     = 1'b1;
				// only clear, soh and stx inside the control range act as control
				if (code >= cfg.clear_code && code < cfg.first_free_code &&
				    (code == cfg.clear_code || code == cfg.soh_code ||
				     code == cfg.stx_code)) begin
					cw_d   = INIT_W;
					lim_d  = INIT_LIM;
					acc_d  = '0;
					bits_d = '0;
					if (group_d != '0) begin
						disc_d = 1'b1;
					end
				end
			end
			if (group_d == '0) begin
				acc_d  = '0;
				bits_d = '0;
			end
		end
	end

	assign has_result        = have_code | item.stream_end;
	assign res.code_value    = have_code ? code : '0;
	assign res.code_valid    = have_code;
	assign res.end_of_stream = item.stream_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q           <= '0;
			bits_held_q     <= '0;
			code_width_q    <= INIT_W;
			width_limit_q   <= INIT_LIM;
			group_left_q    <= '0;
			discarding_q    <= 1'b0;
			check_pending_q <= 1'b0;
		end else if (en) begin
			if (item.stream_end) begin
				acc_q           <= '0;
				bits_held_q     <= '0;
				code_width_q    <= INIT_W;
				width_limit_q   <= INIT_LIM;
				group_left_q    <= '0;
				discarding_q    <= 1'b0;
				check_pending_q <= 1'b0;
			end else begin
				acc_q           <= acc_d;
				bits_held_q     <= bits_d;
				code_width_q    <= cw_d;
				width_limit_q   <= lim_d;
				group_left_q    <= group_d;
				discarding_q    <= disc_d;
				check_pending_q <= chk_d;
			end
		end
	end

	// a code never stays whole in the accumulator past its byte
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_held_q < COUNT_W'(CODE_W))
		else $error("bits held reached a full code width");

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		code_width_q >= INIT_W && code_width_q <= COUNT_W'(CODE_W))
		else $error("code width out of range");

	a_discard_group: assert property (@(posedge clk) disable iff (!arst_n)
		discarding_q |-> group_left_q != '0)
		else $error("discarding with no bytes left in the group");

	a_group_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		group_left_q == '0 |-> bits_held_q == '0 && acc_q == '0)
		else $error("bits left over at a group boundary");

endmodule

>>> hw/rtl/lzw_variable_width_code_unpacker.sv
`timescale 1ns / 1ps

// Unpacks LSB-first variable width LZW codes from a byte stream.
// Input channel s_*: one compressed byte per transaction. s_tlast marks the
// last byte of a stream, s_tdata also carries the decoder's next free code
// so the unpacker can decide when the code width grows.
// Output channel m_*: at most one transaction per input byte. m_tuser is 1
// when m_tdata holds a completed code, m_tlast answers the stream's last
// byte (possibly with no code). Bytes that finish no code and are not last
// produce nothing.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 max_bits,
// 1 max_max_code, 2 clear_code, 3 soh_code, 4 stx_code, 5 first_free_code);
// write only while no stream data is in flight.
// The input register holds each byte, then the unpack logic writes the
// output register that drives m_tvalid. Throughput is one byte per cycle
// while no pending result blocks the output, set by the accumulator update.
// Reset clears the stream state and loads the default configuration. When
// the receiver stalls with a result pending, a following byte that yields a
// result waits in the input register and s_tready drops; bytes with no result
// keep flowing.
module lzw_variable_width_code_unpacker #(
	parameter int INIT_WIDTH = lzwvu_pkg::DEF_INIT_WIDTH,
	parameter int MAX_WIDTH  = lzwvu_pkg::DEF_MAX_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [31:0]                          s_tdata,   // data_byte, dict_next
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [15:0]                          m_tdata,   // code_value
	output logic                                 m_tuser,   // code_valid
	output logic                                 m_tlast,
	input  logic                                 cfg_we,
	input  logic [lzwvu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lzwvu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import lzwvu_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;
	logic    has_result;
	logic    proc_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_bits        <= RST_MAX_BITS;
			cfg_q.max_max_code    <= RST_MAX_MAX_CODE;
			cfg_q.clear_code      <= RST_CLEAR_CODE;
			cfg_q.soh_code        <= RST_SOH_CODE;
			cfg_q.stx_code        <= RST_STX_CODE;
			cfg_q.first_free_code <= RST_FIRST_FREE_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_BITS:        cfg_q.max_bits        <= cfg_wdata[COUNT_W-1:0];
				REG_MAX_MAX_CODE:    cfg_q.max_max_code    <= cfg_wdata[LIMIT_W-1:0];
				REG_CLEAR_CODE:      cfg_q.clear_code      <= cfg_wdata[CODE_W-1:0];
				REG_SOH_CODE:        cfg_q.soh_code        <= cfg_wdata[CODE_W-1:0];
				REG_STX_CODE:        cfg_q.stx_code        <= cfg_wdata[CODE_W-1:0];
				REG_FIRST_FREE_CODE: cfg_q.first_free_code <= cfg_wdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// the held byte is consumed unless it makes a result and the output is blocked
	assign proc_en  = valid_s1 && (!out_valid_q || m_tready || !has_result);
	assign s_tready = !valid_s1 || proc_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte  <= s_tdata[BYTE_W-1:0];
			item_s1.dict_next  <= s_tdata[BYTE_W+LIMIT_W-1:BYTE_W];
			item_s1.stream_end <= s_tlast;
		end
	end

	lzwvu_step #(
		.INIT_WIDTH (INIT_WIDTH),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (proc_en),
		.item       (item_s1),
		.cfg        (cfg_q),
		.has_result (has_result),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_en && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en && has_result) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q.code_value;
	assign m_tuser  = res_q.code_valid;
	assign m_tlast  = res_q.end_of_stream;

endmodule
